// ----- hw/rtl/dhte_pkg.sv -----
// Shared types and constants for the double hashing table engine.
package dhte_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 101;
  localparam int unsigned STEP_BASE_DEF  = 97;
  localparam int unsigned KEY_BYTES      = 8;
  localparam int unsigned KEY_W          = 8 * KEY_BYTES;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned HASH_W         = 32;
  localparam int unsigned HASH_BYTES     = HASH_W / 8;
  localparam int unsigned CNT_W          = 7;

  localparam logic [HASH_W-1:0] HASH_SEED   = 32'd5381;
  localparam logic [CNT_W-1:0]  MAX_ENT_RST = 7'd75;

  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  typedef struct packed {
    logic       load;
    logic       hash;
    logic       modr;
    logic       prep;
    logic       eval;
    logic       publish;
    logic [2:0] byte_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic skip;
    logic ev_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- hw/rtl/double_hash_table_engine.sv -----
// Top level of the double hashing open-addressing table engine.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | in_cmd, in_key, in_value_in
//  out     | output    | out_valid/out_ready | out_status, out_value_out
//  cfg     | input     | cfg_we              | cfg_wdata (max_entries)
//
// One transaction at a time: key hashing, modulo reduction and a setup step,
// then for each probed slot a registered slot memory read and a compare,
// then the output register: out_valid rises together with in_ready (no
// probes for an unused command or an insert at the limit).
// Synchronous active-low reset empties all slots and zeroes the live count.
// A new transaction is taken while a finished result waits on out_ready.
module double_hash_table_engine #(
  parameter int unsigned TABLE_SIZE = dhte_pkg::TABLE_SIZE_DEF,
  parameter int unsigned STEP_BASE  = dhte_pkg::STEP_BASE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_cmd,
  input  logic [dhte_pkg::KEY_W-1:0]   in_key,
  input  logic [dhte_pkg::VALUE_W-1:0] in_value_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [dhte_pkg::VALUE_W-1:0] out_value_out,
  input  logic                         cfg_we,
  input  logic [dhte_pkg::CNT_W-1:0]   cfg_wdata
);
  import dhte_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  dhte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dhte_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .STEP_BASE  (STEP_BASE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .in_value_in   (in_value_in),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_out (out_value_out)
  );

endmodule

// ----- hw/rtl/dhte_ctrl.sv -----
// Controller state machine: sequences hashing, reduction, probing and result hand-off.
module dhte_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dhte_pkg::dp_stat_t stat,
  output dhte_pkg::ctl_cmd_t cmd
);
  import dhte_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_EV   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.byte_sel = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'(KEY_BYTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.modr = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'(HASH_BYTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.skip ? S_DONE : S_RD;
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.ev_done ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/dhte_dp.sv -----
// Datapath: hash, modulo reduction, slot memories, probe address and result registers.
module dhte_dp #(
  parameter int unsigned TABLE_SIZE = dhte_pkg::TABLE_SIZE_DEF,
  parameter int unsigned STEP_BASE  = dhte_pkg::STEP_BASE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dhte_pkg::ctl_cmd_t          cmd,
  output dhte_pkg::dp_stat_t          stat,
  input  logic [1:0]                  in_cmd,
  input  logic [dhte_pkg::KEY_W-1:0]  in_key,
  input  logic [dhte_pkg::VALUE_W-1:0] in_value_in,
  input  logic                        cfg_we,
  input  logic [dhte_pkg::CNT_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [dhte_pkg::VALUE_W-1:0] out_value_out
);
  import dhte_pkg::*;

  // Step must stay below the table size so one subtract wraps the index.
  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned MX = (TABLE_SIZE > STEP_BASE) ? TABLE_SIZE : STEP_BASE;
  localparam int unsigned RW = $clog2(MX);

  function automatic logic [RW-1:0] rem8(input logic [RW-1:0] r, input logic [7:0] b,
                                         input logic [RW:0] m);
    logic [RW:0] t;
    t = {1'b0, r};
    for (int i = 7; i >= 0; i--) begin
      t = {t[RW-1:0], b[i]};
      if (t >= m) t = t - m;
    end
    return t[RW-1:0];
  endfunction

  logic [1:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] val_r;
  logic [HASH_W-1:0]  h_r;
  logic               zseen_r;
  logic [RW-1:0]      rt_r, rs_r;
  logic [IW-1:0]      idx_r, step_r, pc_r;
  logic [CNT_W-1:0]   live_r, max_r;
  logic [1:0]         res_status_r;
  logic [VALUE_W-1:0] res_value_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [VALUE_W-1:0] out_value_r;

  logic [1:0]         mark_mem [TABLE_SIZE];
  logic [KEY_W-1:0]   key_mem  [TABLE_SIZE];
  logic [VALUE_W-1:0] val_mem  [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_r;
  logic [1:0]         mark_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;
  logic               vld_q;

  logic [7:0]  kbyte, hbyte;
  logic [5:0]  kshift;
  logic [1:0]  mark_eff;
  logic        hit, fin, last_probe;
  logic [IW:0] idx_sum;
  logic [RW:0] step_full;

  always_comb begin
    kshift     = 6'(8 * (KEY_BYTES - 1 - 32'(cmd.byte_sel)));
    kbyte      = 8'(key_r >> kshift);
    hbyte      = 8'(h_r >> (8 * (HASH_BYTES - 1 - 32'(cmd.byte_sel[1:0]))));
    mark_eff   = vld_q ? mark_q : MARK_EMPTY;
    hit        = (mark_eff == MARK_USED) && (key_q == key_r);
    if (op_r == CMD_INSERT) fin = (mark_eff != MARK_USED);
    else                    fin = (mark_eff == MARK_EMPTY) || hit;
    last_probe = (pc_r == IW'(TABLE_SIZE - 1));
    idx_sum    = {1'b0, idx_r} + {1'b0, step_r};
    step_full  = (RW+1)'(STEP_BASE) - {1'b0, rs_r};
    stat.skip     = (op_r != CMD_GET && op_r != CMD_INSERT && op_r != CMD_REMOVE) ||
                    (op_r == CMD_INSERT && live_r >= max_r);
    stat.ev_done  = fin || last_probe;
    stat.out_busy = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    mark_q <= mark_mem[idx_r];
    key_q  <= key_mem[idx_r];
    val_q  <= val_mem[idx_r];
    vld_q  <= vld_r[idx_r];
    if (cmd.eval && fin) begin
      if (op_r == CMD_INSERT) begin
        mark_mem[idx_r] <= MARK_USED;
        key_mem[idx_r]  <= key_r;
        val_mem[idx_r]  <= val_r;
      end else if (op_r == CMD_REMOVE && hit) begin
        mark_mem[idx_r] <= MARK_DELETED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_cmd;
      key_r   <= in_key;
      val_r   <= in_value_in;
      h_r     <= HASH_SEED;
      zseen_r <= 1'b0;
      rt_r    <= '0;
      rs_r    <= '0;
    end
    if (cmd.hash) begin
      if (zseen_r || kbyte == 8'd0) begin
        zseen_r <= 1'b1;
        key_r   <= key_r & ~(KEY_W'(8'hFF) << kshift);
      end else begin
        h_r <= (h_r << 5) + h_r + HASH_W'(kbyte);
      end
    end
    if (cmd.modr) begin
      rt_r <= rem8(rt_r, hbyte, (RW+1)'(TABLE_SIZE));
      rs_r <= rem8(rs_r, hbyte, (RW+1)'(STEP_BASE));
    end
    if (cmd.prep) begin
      idx_r        <= rt_r[IW-1:0];
      step_r       <= step_full[IW-1:0];
      pc_r         <= '0;
      res_status_r <= (op_r == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
      res_value_r  <= '0;
    end
    if (cmd.eval) begin
      if (fin) begin
        // empty slot ends a lookup with not found
        if (op_r == CMD_INSERT || hit) begin
          res_status_r <= ST_OK;
          res_value_r  <= (op_r == CMD_INSERT) ? '0 : val_q;
        end
      end else begin
        pc_r  <= pc_r + 1'b1;
        idx_r <= (idx_sum >= (IW+1)'(TABLE_SIZE)) ? IW'(idx_sum - (IW+1)'(TABLE_SIZE))
                                                   : idx_sum[IW-1:0];
      end
    end
    if (cmd.publish) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      live_r      <= '0;
      max_r       <= MAX_ENT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (cmd.eval && fin) begin
        if (op_r == CMD_INSERT) begin
          vld_r[idx_r] <= 1'b1;
          live_r       <= live_r + 1'b1;
        end else if (op_r == CMD_REMOVE && hit && live_r != '0) begin
          live_r <= live_r - 1'b1;
        end
      end
      if (cmd.publish)               out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

endmodule

// ----- hw/rtl/dhte_chk.sv -----
// Port-level checker for the double hashing table engine, bound to the top level.
module dhte_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_value_out
);
  import dhte_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value_out))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOT_FOUND || out_status == ST_FULL))
    else $error("bad status code");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value_out == '0)
    else $error("nonzero value on failed transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind double_hash_table_engine dhte_chk u_dhte_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_value_out (out_value_out)
);
